FILE: src/mpfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_pkg
// Shared types and constants of the motor PID / feedforward drive block.
// ----------------------------------------------------------------------------
package mpfd_pkg;

  localparam int unsigned PWM_LIMIT = 255;
  localparam int unsigned DEAD_BAND = 10;
  localparam int unsigned DUTY_MAX  = 255;

  // log2(e) in Q.30 and ln(2) in Q0.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;

  // feedforward magnitude cap, 2^46-1
  localparam logic [45:0] FF_CAP = '1;

  localparam int unsigned TAYLOR_TERMS = 12;

  // shared multiplier operand/product widths
  localparam int unsigned MUL_A_W = 37;
  localparam int unsigned MUL_B_W = 33;
  localparam int unsigned MUL_P_W = 64;

  // divider widths
  localparam int unsigned DIV_N_W = 34;
  localparam int unsigned DIV_D_W = 16;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET   = 3'd0,
    CFG_GAIN_P   = 3'd1,
    CFG_GAIN_I   = 3'd2,
    CFG_GAIN_D   = 3'd3,
    CFG_FF_SCALE = 3'd4,
    CFG_FF_EXP   = 3'd5
  } mpfd_cfg_e;

  typedef enum logic [3:0] {
    OP_ERR   = 4'd0,   // form error and error delta
    OP_EDT   = 4'd1,   // err*dt, integrate
    OP_DERIV = 4'd2,   // delta/dt
    OP_BX    = 4'd3,   // x = B*|target|
    OP_XL    = 4'd4,   // y = x*log2(e)
    OP_FL    = 4'd5,   // r = frac(y)*ln2
    OP_TR    = 4'd6,   // term*r
    OP_TN    = 4'd7,   // term/n, accumulate
    OP_AV    = 4'd8,   // A*series
    OP_FFSH  = 4'd9,   // scale by 2^k, saturate
    OP_P     = 4'd10,
    OP_I     = 4'd11,
    OP_D     = 4'd12
  } mpfd_op_e;

  typedef struct packed {
    logic     load;
    logic     start;
    mpfd_op_e op;
    logic     finish;
  } mpfd_cmd_t;

  typedef struct packed {
    logic done;
    logic tgt_zero;
    logic last_term;
  } mpfd_stat_t;

endpackage

FILE: src/mpfd_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_mul
// Shared signed multiplier, shift-and-add, one multiplier bit per cycle.
// Stops as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module mpfd_mul (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     start_i,
  input  logic signed [mpfd_pkg::MUL_A_W-1:0]      a_i,
  input  logic signed [mpfd_pkg::MUL_B_W-1:0]      b_i,
  output logic                                     done_o,
  output logic signed [mpfd_pkg::MUL_P_W-1:0]      p_o
);

  logic                               busy_q;
  logic                               done_q;
  logic                               neg_q;
  logic [mpfd_pkg::MUL_P_W-1:0]       am_q;
  logic [mpfd_pkg::MUL_B_W-1:0]       bm_q;
  logic [mpfd_pkg::MUL_P_W-1:0]       acc_q;
  logic signed [mpfd_pkg::MUL_P_W-1:0] p_q;
  logic [mpfd_pkg::MUL_A_W-1:0]       a_mag;
  logic [mpfd_pkg::MUL_B_W-1:0]       b_mag;

  assign a_mag = a_i[mpfd_pkg::MUL_A_W-1] ? mpfd_pkg::MUL_A_W'(-a_i) : a_i;
  assign b_mag = b_i[mpfd_pkg::MUL_B_W-1] ? mpfd_pkg::MUL_B_W'(-b_i) : b_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && bm_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      am_q  <= mpfd_pkg::MUL_P_W'(a_mag);
      bm_q  <= b_mag;
      neg_q <= a_i[mpfd_pkg::MUL_A_W-1] ^ b_i[mpfd_pkg::MUL_B_W-1];
      acc_q <= '0;
    end else if (busy_q) begin
      if (bm_q == '0) begin
        p_q <= neg_q ? -$signed(acc_q) : $signed(acc_q);
      end else begin
        if (bm_q[0]) acc_q <= acc_q + am_q;
        am_q <= am_q << 1;
        bm_q <= bm_q >> 1;
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = p_q;

endmodule

FILE: src/mpfd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpfd_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [mpfd_pkg::DIV_N_W-1:0]      num_i,
  input  logic [mpfd_pkg::DIV_D_W-1:0]      den_i,
  output logic                              done_o,
  output logic [mpfd_pkg::DIV_N_W-1:0]      quo_o
);

  localparam int unsigned CntW = $clog2(mpfd_pkg::DIV_N_W + 1);

  logic                             busy_q;
  logic                             done_q;
  logic [CntW-1:0]                  cnt_q;
  logic [mpfd_pkg::DIV_N_W-1:0]     quo_q;
  logic [mpfd_pkg::DIV_D_W:0]       rem_q;
  logic [mpfd_pkg::DIV_D_W-1:0]     den_q;
  logic [mpfd_pkg::DIV_D_W:0]       rem_s;
  logic [mpfd_pkg::DIV_D_W:0]       rem_d;
  logic                             bit_d;

  always_comb begin
    rem_s = {rem_q[mpfd_pkg::DIV_D_W-1:0], quo_q[mpfd_pkg::DIV_N_W-1]};
    bit_d = (rem_s >= {1'b0, den_q});
    rem_d = bit_d ? rem_s - {1'b0, den_q} : rem_s;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CntW'(mpfd_pkg::DIV_N_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[mpfd_pkg::DIV_N_W-2:0], bit_d};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

FILE: src/mpfd_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_dp
// Datapath: configuration registers, controller state, shared multiplier and
// divider, feedforward series and the output payload register.
// ----------------------------------------------------------------------------
module mpfd_dp #(
  parameter int unsigned PwmLimit = mpfd_pkg::PWM_LIMIT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mpfd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [15:0]                       cfg_data_i,
  input  logic [15:0]                       meas_i,
  input  logic [15:0]                       dt_i,
  input  mpfd_pkg::mpfd_cmd_t               cmd_i,
  output mpfd_pkg::mpfd_stat_t              stat_o,
  output logic                              fwd_o,
  output logic                              rev_o,
  output logic [7:0]                        duty_o,
  output logic                              upd_o
);

  localparam logic [47:0] LimW  = 48'(PwmLimit);
  localparam logic [47:0] DeadW = 48'(mpfd_pkg::DEAD_BAND);
  localparam logic [47:0] DutyW = 48'(mpfd_pkg::DUTY_MAX);

  // configuration
  logic signed [15:0] tgt_q, kp_q, ki_q, kd_q, ffb_q;
  logic        [15:0] ffa_q;

  // item and control state
  logic signed [15:0] meas_q;
  logic        [15:0] dt_q;
  logic signed [31:0] integ_q;
  logic signed [16:0] prev_q;
  logic        [7:0]  held_q;

  // working registers
  logic signed [16:0] err_q;
  logic signed [17:0] diff_q;
  logic        [16:0] abs_t_q;
  logic signed [35:0] deriv_q;
  logic signed [33:0] x_q;
  logic signed [31:0] y_q;
  logic        [29:0] r_q;
  logic        [30:0] term_q;
  logic        [31:0] tsum_q;
  logic        [3:0]  n_q;
  logic        [47:0] v_q;
  logic signed [63:0] acc_q;
  mpfd_pkg::mpfd_op_e op_q;
  logic               simple_q;

  logic fwd_q, rev_q, upd_q;
  logic [7:0] duty_q;

  // shared units
  logic                                 mul_start, mul_done;
  logic signed [mpfd_pkg::MUL_A_W-1:0]  mul_a;
  logic signed [mpfd_pkg::MUL_B_W-1:0]  mul_b;
  logic signed [mpfd_pkg::MUL_P_W-1:0]  mul_p;
  logic                                 div_start, div_done;
  logic [mpfd_pkg::DIV_N_W-1:0]         div_num, div_q;
  logic [mpfd_pkg::DIV_D_W-1:0]         div_den;
  logic                                 is_mul, is_div, done;

  logic signed [16:0] err_c;
  logic signed [17:0] diff_c;
  logic        [17:0] abs_diff;
  logic signed [63:0] p_shr16;
  logic signed [33:0] integ_sum;
  logic signed [31:0] integ_d;
  logic signed [35:0] deriv_d;

  mpfd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  mpfd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_q)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tgt_q <= '0;
      kp_q  <= '0;
      ki_q  <= '0;
      kd_q  <= '0;
      ffa_q <= '0;
      ffb_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mpfd_pkg::CFG_TARGET:   tgt_q <= cfg_data_i;
        mpfd_pkg::CFG_GAIN_P:   kp_q  <= cfg_data_i;
        mpfd_pkg::CFG_GAIN_I:   ki_q  <= cfg_data_i;
        mpfd_pkg::CFG_GAIN_D:   kd_q  <= cfg_data_i;
        mpfd_pkg::CFG_FF_SCALE: ffa_q <= cfg_data_i;
        mpfd_pkg::CFG_FF_EXP:   ffb_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign err_c  = 17'(tgt_q) - 17'(meas_q);
  assign diff_c = 18'(err_c) - 18'(prev_q);
  assign abs_diff = diff_q[17] ? 18'(-diff_q) : 18'(diff_q);

  always_comb begin
    is_mul = 1'b0;
    is_div = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    div_num = '0;
    div_den = '0;
    case (cmd_i.op)
      mpfd_pkg::OP_EDT: begin
        is_mul = 1'b1;
        mul_a  = 37'(err_q);
        mul_b  = 33'(dt_q);
      end
      mpfd_pkg::OP_DERIV: begin
        is_div  = (dt_q != '0);
        div_num = {abs_diff[17:0], 16'b0};
        div_den = dt_q;
      end
      mpfd_pkg::OP_BX: begin
        is_mul = 1'b1;
        mul_a  = 37'(ffb_q);
        mul_b  = 33'(abs_t_q);
      end
      mpfd_pkg::OP_XL: begin
        is_mul = 1'b1;
        mul_a  = 37'(x_q);
        mul_b  = 33'(mpfd_pkg::LOG2E_Q30);
      end
      mpfd_pkg::OP_FL: begin
        is_mul = 1'b1;
        mul_a  = 37'(y_q[19:0]);
        mul_b  = 33'(mpfd_pkg::LN2_Q30);
      end
      mpfd_pkg::OP_TR: begin
        is_mul = 1'b1;
        mul_a  = 37'(term_q);
        mul_b  = 33'(r_q);
      end
      mpfd_pkg::OP_TN: begin
        is_div  = 1'b1;
        div_num = mul_p[63:30];
        div_den = 16'(n_q);
      end
      mpfd_pkg::OP_AV: begin
        is_mul = 1'b1;
        mul_a  = 37'(tsum_q);
        mul_b  = 33'(ffa_q);
      end
      mpfd_pkg::OP_P: begin
        is_mul = 1'b1;
        mul_a  = 37'(err_q);
        mul_b  = 33'(kp_q);
      end
      mpfd_pkg::OP_I: begin
        is_mul = 1'b1;
        mul_a  = 37'(integ_q);
        mul_b  = 33'(ki_q);
      end
      mpfd_pkg::OP_D: begin
        is_mul = 1'b1;
        mul_a  = 37'(deriv_q);
        mul_b  = 33'(kd_q);
      end
      default: ;
    endcase
  end

  assign mul_start = cmd_i.start & is_mul;
  assign div_start = cmd_i.start & is_div;
  assign done      = mul_done | div_done | simple_q;

  // integral update, saturating to 32 bits
  always_comb begin
    p_shr16   = mul_p >>> 16;
    integ_sum = 34'(integ_q) + p_shr16[33:0];
    if (integ_sum > 34'sh0_7FFF_FFFF)       integ_d = 32'sh7FFF_FFFF;
    else if (integ_sum < -34'sh0_8000_0000) integ_d = 32'sh8000_0000;
    else                                    integ_d = integ_sum[31:0];
  end

  assign deriv_d = diff_q[17] ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});

  // feedforward scale by 2^(k-22) with saturation
  logic signed [12:0] sh;
  logic        [12:0] nsh;
  logic        [47:0] v_shl;
  logic        [45:0] ffm;
  logic signed [47:0] ffs;

  always_comb begin
    sh    = 13'($signed(y_q[31:20])) - 13'sd22;
    nsh   = 13'(-sh);
    v_shl = v_q << sh[5:0];
    ffm   = '0;
    if (v_q == '0) begin
      ffm = '0;
    end else if (!sh[12]) begin
      if (sh >= 13'sd47)                             ffm = mpfd_pkg::FF_CAP;
      else if ((v_q >> (6'd46 - sh[5:0])) != '0)     ffm = mpfd_pkg::FF_CAP;
      else                                           ffm = v_shl[45:0];
    end else begin
      if (nsh >= 13'd48) ffm = '0;
      else               ffm = 46'(v_q >> nsh[5:0]);
    end
    ffs = tgt_q[15] ? -$signed({2'b0, ffm}) : $signed({2'b0, ffm});
  end

  // command: truncate toward zero, clamp, deadband
  logic [63:0] sum_mag;
  logic [47:0] cmd_mag, cmd_clamp;
  logic        dead;

  always_comb begin
    sum_mag   = acc_q[63] ? 64'(-acc_q) : 64'(acc_q);
    cmd_mag   = sum_mag[63:16];
    cmd_clamp = (cmd_mag > LimW) ? LimW : cmd_mag;
    dead      = (cmd_clamp <= DeadW);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q  <= '0;
      prev_q   <= '0;
      held_q   <= '0;
      simple_q <= 1'b0;
      op_q     <= mpfd_pkg::OP_ERR;
    end else begin
      simple_q <= cmd_i.start & ~is_mul & ~is_div;
      if (cmd_i.start) op_q <= cmd_i.op;
      if (done) begin
        case (op_q)
          mpfd_pkg::OP_EDT: begin
            integ_q <= integ_d;
            prev_q  <= err_q;
          end
          default: ;
        endcase
      end
      if (cmd_i.finish && !dead) begin
        held_q <= (cmd_clamp > DutyW) ? 8'(DutyW) : cmd_clamp[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      meas_q <= meas_i;
      dt_q   <= dt_i;
      acc_q  <= '0;
    end
    if (done) begin
      case (op_q)
        mpfd_pkg::OP_ERR: begin
          err_q   <= err_c;
          diff_q  <= diff_c;
          abs_t_q <= tgt_q[15] ? 17'(-17'(tgt_q)) : 17'(tgt_q);
        end
        mpfd_pkg::OP_DERIV: deriv_q <= (dt_q == '0) ? '0 : deriv_d;
        mpfd_pkg::OP_BX:    x_q     <= mul_p[33:0];
        mpfd_pkg::OP_XL:    y_q     <= 32'(mul_p >>> 30);
        mpfd_pkg::OP_FL: begin
          r_q    <= mul_p[49:20];
          term_q <= 31'h4000_0000;
          tsum_q <= 32'h4000_0000;
          n_q    <= 4'd1;
        end
        mpfd_pkg::OP_TN: begin
          term_q <= div_q[30:0];
          tsum_q <= tsum_q + div_q[31:0];
          n_q    <= n_q + 4'd1;
        end
        mpfd_pkg::OP_AV:   v_q   <= mul_p[47:0];
        mpfd_pkg::OP_FFSH: acc_q <= 64'(ffs);
        mpfd_pkg::OP_P, mpfd_pkg::OP_I, mpfd_pkg::OP_D: acc_q <= acc_q + mul_p;
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      if (dead) begin
        fwd_q  <= 1'b0;
        rev_q  <= 1'b0;
        duty_q <= held_q;
        upd_q  <= 1'b0;
      end else begin
        fwd_q  <= ~acc_q[63];
        rev_q  <= acc_q[63];
        duty_q <= (cmd_clamp > DutyW) ? 8'(DutyW) : cmd_clamp[7:0];
        upd_q  <= 1'b1;
      end
    end
  end

  assign stat_o.done      = done;
  assign stat_o.tgt_zero  = (tgt_q == '0);
  assign stat_o.last_term = (n_q == 4'(mpfd_pkg::TAYLOR_TERMS));

  assign fwd_o  = fwd_q;
  assign rev_o  = rev_q;
  assign duty_o = duty_q;
  assign upd_o  = upd_q;

endmodule

FILE: src/mpfd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_ctrl
// Sequencer: walks the datapath through one update and owns both handshakes.
// ----------------------------------------------------------------------------
module mpfd_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output mpfd_pkg::mpfd_cmd_t   cmd_o,
  input  mpfd_pkg::mpfd_stat_t  stat_i
);

  typedef enum logic [14:0] {
    ST_IDLE  = 15'b000000000000001,
    ST_ERR   = 15'b000000000000010,
    ST_EDT   = 15'b000000000000100,
    ST_DERIV = 15'b000000000001000,
    ST_BX    = 15'b000000000010000,
    ST_XL    = 15'b000000000100000,
    ST_FL    = 15'b000000001000000,
    ST_TR    = 15'b000000010000000,
    ST_TN    = 15'b000000100000000,
    ST_AV    = 15'b000001000000000,
    ST_FFSH  = 15'b000010000000000,
    ST_P     = 15'b000100000000000,
    ST_I     = 15'b001000000000000,
    ST_D     = 15'b010000000000000,
    ST_FIN   = 15'b100000000000000
  } mpfd_state_e;

  mpfd_state_e state_q, state_d, next_c;
  logic        issued_q, issued_d;
  logic        out_valid_q, out_valid_d;
  mpfd_pkg::mpfd_op_e op_c;

  always_comb begin
    op_c   = mpfd_pkg::OP_ERR;
    next_c = ST_IDLE;
    unique case (state_q)
      ST_ERR:   begin op_c = mpfd_pkg::OP_ERR;   next_c = ST_EDT;   end
      ST_EDT:   begin op_c = mpfd_pkg::OP_EDT;   next_c = ST_DERIV; end
      ST_DERIV: begin op_c = mpfd_pkg::OP_DERIV; next_c = ST_BX;    end
      ST_BX:    begin op_c = mpfd_pkg::OP_BX;    next_c = ST_XL;    end
      ST_XL:    begin op_c = mpfd_pkg::OP_XL;    next_c = ST_FL;    end
      ST_FL:    begin op_c = mpfd_pkg::OP_FL;    next_c = ST_TR;    end
      ST_TR:    begin op_c = mpfd_pkg::OP_TR;    next_c = ST_TN;    end
      ST_TN: begin
        op_c   = mpfd_pkg::OP_TN;
        next_c = stat_i.last_term ? ST_AV : ST_TR;
      end
      ST_AV:    begin op_c = mpfd_pkg::OP_AV;    next_c = ST_FFSH;  end
      ST_FFSH:  begin op_c = mpfd_pkg::OP_FFSH;  next_c = ST_P;     end
      ST_P:     begin op_c = mpfd_pkg::OP_P;     next_c = ST_I;     end
      ST_I:     begin op_c = mpfd_pkg::OP_I;     next_c = ST_D;     end
      ST_D:     begin op_c = mpfd_pkg::OP_D;     next_c = ST_FIN;   end
      ST_IDLE, ST_FIN: ;
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    issued_d    = issued_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    in_ready_o  = 1'b0;
    cmd_o       = '{load: 1'b0, start: 1'b0, op: op_c, finish: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.tgt_zero ? ST_FIN : ST_ERR;
        end
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        cmd_o.start = ~issued_q;
        issued_d    = 1'b1;
        if (stat_i.done) begin
          issued_d = 1'b0;
          state_d  = next_c;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      issued_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issued_q    <= issued_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: src/motor_pid_feedforward_drive_top.sv
`timescale 1ns / 1ps
// The shared shift-add multiplier (one bit per cycle, up to 31 bits) and restoring divider
// set the time an item with a nonzero target takes; the 12-term exp series uses both
// twelve times. An item with a zero target goes straight to the output register.
// Throughput: one item per update; the next item is taken once the result is in the
// output register. Reset (rst_ni low, async) clears configuration, integral, previous
// error and held duty.
// ----------------------------------------------------------------------------
// motor_pid_feedforward_drive_top
// Velocity PID with exponential feedforward driving direction pins and PWM duty.
// ----------------------------------------------------------------------------
module motor_pid_feedforward_drive_top #(
  parameter int unsigned PwmLimit = mpfd_pkg::PWM_LIMIT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [15:0] measured_velocity, [31:16] elapsed_time
  input  logic [31:0]                      s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] drive_forward, [1] drive_reverse, [9:2] pwm_duty, [10] pwm_updated
  output logic [15:0]                      m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [mpfd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [15:0]                      cfg_data_i
);

  mpfd_pkg::mpfd_cmd_t  cmd;
  mpfd_pkg::mpfd_stat_t stat;
  logic       fwd, rev, upd;
  logic [7:0] duty;

  mpfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  mpfd_dp #(
    .PwmLimit (PwmLimit)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .meas_i      (s_axis_tdata[15:0]),
    .dt_i        (s_axis_tdata[31:16]),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .fwd_o       (fwd),
    .rev_o       (rev),
    .duty_o      (duty),
    .upd_o       (upd)
  );

  assign m_axis_tdata = {5'b0, upd, duty, rev, fwd};

endmodule

FILE: src/mpfd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mpfd_checker
// Port-level checks of the drive block, bound to the top level.
// ----------------------------------------------------------------------------
module mpfd_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [31:0]                    s_axis_tdata,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [15:0]                    m_axis_tdata,
  input logic                           cfg_we_i,
  input logic [mpfd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [15:0]                    cfg_data_i
);

  // never drive both bridge sides
  a_pins_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("both direction pins high");

  // deadband beats release both pins
  a_dead_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[10]) |-> (m_axis_tdata[1:0] == 2'b00))
    else $error("pins driven without duty update");

  // an updated duty lies outside the deadband
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[10]) |-> (m_axis_tdata[9:2] > 8'd10))
    else $error("updated duty inside deadband");

  // one item at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second beat taken while busy");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind motor_pid_feedforward_drive_top mpfd_checker u_mpfd_checker (.*);

FILE: tb/tb_motor_pid_feedforward_drive_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_motor_pid_feedforward_drive_top
// Drives velocity/elapsed-time beats into the PID drive block under several register
// settings and compares each output beat with a hand-set result or a bit-exact
// predictor of the PID, integral saturation, exp feedforward, clamp and deadband logic.
// ----------------------------------------------------------------------------
module tb_motor_pid_feedforward_drive_top;
  import mpfd_pkg::*;

  typedef struct packed {
    logic       fwd;
    logic       rev;
    logic [7:0] duty;
    logic       upd;
  } drive_res_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    mpfd_cfg_e  idx;
    logic [15:0] val;
    logic [15:0] meas;
    logic [15:0] dt;
    bit         typed;
    drive_res_t res;
  } stim_row_t;

  localparam longint unsigned FF_SAT = (64'd1 << 46) - 1;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [15:0] cfg_data_i;

  // predictor copy of registers and state
  logic [15:0] p_target, p_kp, p_ki, p_kd, p_ffa, p_ffb;
  int          p_integ;
  longint      p_prev_err;
  logic [7:0]  p_held;

  drive_res_t  duty_q[$];
  int          fails;
  int          burst_left;
  stim_row_t   rows[$];

  motor_pid_feedforward_drive_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("tb_motor_pid_feedforward_drive_top NOT OK");
    $finish;
  end

  // |A*exp(x)| in Q16.16, x in Q.20
  function automatic longint unsigned ff_magnitude(longint x);
    longint          y, k, s;
    longint unsigned f, r, term, acc, v;
    y = (x * 64'sd1549082005) >>> 30;
    k = y >>> 20;
    f = longint'(y) & 64'hFFFFF;
    r = (f * 64'd744261118) >> 20;
    term = 64'd1 << 30;
    acc  = 64'd1 << 30;
    for (int n = 1; n <= TAYLOR_TERMS; n++) begin
      term = ((term * r) >> 30) / n;
      acc += term;
    end
    v = longint'(p_ffa) * acc;
    s = k - 22;
    if (v == 0) return 0;
    if (s >= 0) begin
      if (s >= 47 || v > (FF_SAT >> s)) return FF_SAT;
      return v << s;
    end
    if (-s >= 63) return 0;
    return v >> (-s);
  endfunction

  function automatic drive_res_t drive_predict(logic [15:0] meas_raw, logic [15:0] dt_raw);
    longint     tgt, meas, dt, err, deriv, integ, abs_t, ff, acc, cmd, mag;
    drive_res_t r;
    tgt = longint'($signed(p_target));
    cmd = 0;
    if (tgt != 0) begin
      meas  = longint'($signed(meas_raw));
      dt    = longint'(dt_raw);
      err   = tgt - meas;
      deriv = 0;
      integ = longint'(p_integ) + ((err * dt) >>> 16);
      if (integ > 64'sd2147483647) integ = 64'sd2147483647;
      if (integ < -64'sd2147483648) integ = -64'sd2147483648;
      p_integ = int'(integ);
      if (dt != 0) deriv = ((err - p_prev_err) * 65536) / dt;
      p_prev_err = err;
      abs_t = tgt < 0 ? -tgt : tgt;
      ff = longint'(ff_magnitude(longint'($signed(p_ffb)) * abs_t));
      if (tgt < 0) ff = -ff;
      acc = ff + longint'($signed(p_kp)) * err + longint'($signed(p_ki)) * integ
          + longint'($signed(p_kd)) * deriv;
      cmd = acc / 65536;
      if (cmd > longint'(PWM_LIMIT)) cmd = longint'(PWM_LIMIT);
      if (cmd < -longint'(PWM_LIMIT)) cmd = -longint'(PWM_LIMIT);
    end
    mag = cmd < 0 ? -cmd : cmd;
    if (mag <= DEAD_BAND) begin
      r = '{fwd: 1'b0, rev: 1'b0, duty: p_held, upd: 1'b0};
    end else begin
      if (mag > DUTY_MAX) mag = DUTY_MAX;
      p_held = mag[7:0];
      r = '{fwd: cmd > 0, rev: cmd < 0, duty: p_held, upd: 1'b1};
    end
    return r;
  endfunction

  // output side: stall pattern and checking
  int rx_cnt;
  bit rx_on;
  always @(posedge clk_i or negedge rst_ni) begin
    drive_res_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_cnt <= 0;
      rx_on  <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{fwd: m_axis_tdata[0], rev: m_axis_tdata[1],
                duty: m_axis_tdata[9:2], upd: m_axis_tdata[10]};
        if (duty_q.size() == 0) begin
          $error("output beat with nothing expected: %h", m_axis_tdata);
          fails++;
        end else begin
          want = duty_q.pop_front();
          if (got.fwd !== want.fwd) begin
            $error("drive_forward exp %0d got %0d", want.fwd, got.fwd); fails++;
          end
          if (got.rev !== want.rev) begin
            $error("drive_reverse exp %0d got %0d", want.rev, got.rev); fails++;
          end
          if (got.duty !== want.duty) begin
            $error("pwm_duty exp %0d got %0d", want.duty, got.duty); fails++;
          end
          if (got.upd !== want.upd) begin
            $error("pwm_updated exp %0d got %0d", want.upd, got.upd); fails++;
          end
        end
      end
      if (rx_cnt == 0) begin
        rx_on  <= ($urandom_range(0, 2) != 0);
        rx_cnt <= $urandom_range(1, 40);
        m_axis_tready <= rx_on;
      end else begin
        rx_cnt <= rx_cnt - 1;
        m_axis_tready <= rx_on;
      end
    end
  end

  task automatic send_beat(logic [15:0] meas, logic [15:0] dt, bit typed, drive_res_t res);
    drive_res_t pred;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    pred = drive_predict(meas, dt);
    duty_q.push_back(typed ? res : pred);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dt, meas};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (duty_q.size() != 0);
    repeat (10) @(posedge clk_i);
  endtask

  // only called with the block idle
  task automatic write_reg(mpfd_cfg_e idx, logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_TARGET:   p_target = val;
      CFG_GAIN_P:   p_kp = val;
      CFG_GAIN_I:   p_ki = val;
      CFG_GAIN_D:   p_kd = val;
      CFG_FF_SCALE: p_ffa = val;
      CFG_FF_EXP:   p_ffb = val;
      default: ;
    endcase
  endtask

  function automatic void add_cfg(mpfd_cfg_e idx, logic [15:0] val);
    rows.push_back('{kind: ROW_CFG, idx: idx, val: val, meas: '0, dt: '0,
                     typed: 1'b0, res: '0});
  endfunction

  function automatic void add_item(logic [15:0] meas, logic [15:0] dt, bit typed,
                                   drive_res_t res);
    rows.push_back('{kind: ROW_ITEM, idx: CFG_TARGET, val: '0, meas: meas, dt: dt,
                     typed: typed, res: res});
  endfunction

  function automatic logic [15:0] small_gain();
    return 16'($signed($urandom_range(0, 1024)) - 512);
  endfunction

  initial begin
    bool_setup: begin
    end
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_TARGET;
    cfg_data_i    = '0;
    {p_target, p_kp, p_ki, p_kd, p_ffa, p_ffb} = '0;
    p_integ = 0; p_prev_err = 0; p_held = '0;
    fails = 0; burst_left = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero target after reset: pins low, duty held at 0
    add_item(16'h7FFF, 16'hFFFF, 1, '{1'b0, 1'b0, 8'd0, 1'b0});
    add_item(16'h8000, 16'h0001, 1, '{1'b0, 1'b0, 8'd0, 1'b0});
    // full-scale forward and reverse clamp
    add_cfg(CFG_TARGET, 16'h7FFF);
    add_cfg(CFG_GAIN_P, 16'h7FFF);
    add_item(16'h8000, 16'h0001, 1, '{1'b1, 1'b0, 8'd255, 1'b1});
    add_item(16'h7FFF, 16'hFFFF, 1, '{1'b0, 1'b0, 8'd255, 1'b0});
    add_cfg(CFG_TARGET, 16'h8000);
    add_item(16'h7FFF, 16'h0001, 1, '{1'b0, 1'b1, 8'd255, 1'b1});
    // zero elapsed time, integral and derivative extremes
    add_cfg(CFG_GAIN_P, 16'h0010);
    add_cfg(CFG_GAIN_I, 16'h8000);
    add_cfg(CFG_GAIN_D, 16'h7FFF);
    add_item(16'h7FFF, 16'h0000, 0, '0);
    add_item(16'h8000, 16'h0001, 0, '0);
    add_item(16'h7FFF, 16'hFFFF, 0, '0);
    add_item(16'h0000, 16'h0000, 0, '0);
    // feedforward: large and negative exponent, max scale
    add_cfg(CFG_GAIN_P, 16'h0000);
    add_cfg(CFG_GAIN_I, 16'h0000);
    add_cfg(CFG_GAIN_D, 16'h0000);
    add_cfg(CFG_FF_SCALE, 16'hFFFF);
    add_cfg(CFG_FF_EXP, 16'h7FFF);
    add_item(16'h1234, 16'h0100, 0, '0);
    add_cfg(CFG_FF_EXP, 16'h8000);
    add_item(16'h1234, 16'h0100, 0, '0);
    add_cfg(CFG_TARGET, 16'h0100);
    add_cfg(CFG_FF_SCALE, 16'h0A00);
    add_cfg(CFG_FF_EXP, 16'h0800);
    add_item(16'h00F0, 16'h0040, 0, '0);
    add_cfg(CFG_FF_SCALE, 16'h0500);
    add_item(16'h00F0, 16'h0040, 0, '0);
    // back to zero target: held duty shows
    add_cfg(CFG_TARGET, 16'h0000);
    add_item(16'h5555, 16'hAAAA, 0, '0);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (i == 0 || rows[i-1].kind != ROW_CFG) wait_drained();
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        send_beat(rows[i].meas, rows[i].dt, rows[i].typed, rows[i].res);
      end
    end

    // random phases, each with a fresh setting of every register
    for (int ph = 0; ph < 20; ph++) begin
      logic [15:0] tgt;
      logic [15:0] meas;
      logic [15:0] dt;
      int          sel;
      wait_drained();
      sel = $urandom_range(0, 9);
      if (ph == 3) begin
        write_reg(CFG_TARGET, 16'h7FFF); write_reg(CFG_GAIN_P, 16'h7FFF);
        write_reg(CFG_GAIN_I, 16'h7FFF); write_reg(CFG_GAIN_D, 16'h7FFF);
        write_reg(CFG_FF_SCALE, 16'hFFFF); write_reg(CFG_FF_EXP, 16'h7FFF);
      end else if (ph == 7) begin
        write_reg(CFG_TARGET, 16'h8000); write_reg(CFG_GAIN_P, 16'h8000);
        write_reg(CFG_GAIN_I, 16'h8000); write_reg(CFG_GAIN_D, 16'h8000);
        write_reg(CFG_FF_SCALE, 16'h0000); write_reg(CFG_FF_EXP, 16'h8000);
      end else begin
        if (sel == 0) tgt = 16'h0000;
        else if (sel < 4) tgt = 16'($urandom);
        else tgt = 16'($signed($urandom_range(0, 2048)) - 1024);
        write_reg(CFG_TARGET, tgt);
        write_reg(CFG_GAIN_P, sel > 7 ? 16'($urandom) : small_gain());
        write_reg(CFG_GAIN_I, sel > 8 ? 16'($urandom) : small_gain());
        write_reg(CFG_GAIN_D, sel == 5 ? 16'($urandom) : 16'($urandom_range(0, 8)));
        write_reg(CFG_FF_SCALE, 16'($urandom));
        write_reg(CFG_FF_EXP, sel > 6 ? 16'($urandom)
                                      : 16'($signed($urandom_range(0, 8192)) - 4096));
      end
      for (int n = 0; n < 35; n++) begin
        if ($urandom_range(0, 3) == 0) meas = 16'($urandom);
        else meas = 16'($signed(p_target) + $signed($urandom_range(0, 1024)) - 512);
        dt = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                         : 16'($urandom_range(1, 2000));
        send_beat(meas, dt, 0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (duty_q.size() != 0);
    repeat (50) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_motor_pid_feedforward_drive_top OK");
    end else begin
      $display("tb_motor_pid_feedforward_drive_top NOT OK");
    end
    $finish;
  end

endmodule

FILE: motor_pid_feedforward_drive_top.f
src/mpfd_pkg.sv
src/mpfd_mul.sv
src/mpfd_div.sv
src/mpfd_dp.sv
src/mpfd_ctrl.sv
src/motor_pid_feedforward_drive_top.sv
src/mpfd_checker.sv
tb/tb_motor_pid_feedforward_drive_top.sv
